FILE: hdl/isfl_pkg.sv
package isfl_pkg;

    localparam logic [15:0] CIP_HEADER_BYTES = 16'd8;
    localparam logic [4:0]  LOCK_PACKETS     = 5'd16;
    localparam logic [4:0]  CH_ITERS         = 5'd14;
    localparam logic [4:0]  RATE_ITERS       = 5'd18;

    localparam logic [1:0] STATUS_SHORT    = 2'd0;
    localparam logic [1:0] STATUS_LEARNING = 2'd1;
    localparam logic [1:0] STATUS_NO_RATE  = 2'd2;
    localparam logic [1:0] STATUS_ACCEPTED = 2'd3;

    localparam logic [3:0] RATE_UNKNOWN = 4'd0;
    localparam logic [3:0] RATE_8K      = 4'd1;
    localparam logic [3:0] RATE_16K     = 4'd2;
    localparam logic [3:0] RATE_32K     = 4'd3;
    localparam logic [3:0] RATE_44K1    = 4'd4;
    localparam logic [3:0] RATE_48K     = 4'd5;
    localparam logic [3:0] RATE_88K2    = 4'd6;
    localparam logic [3:0] RATE_96K     = 4'd7;
    localparam logic [3:0] RATE_192K    = 4'd8;

    typedef logic [3:0] pc_t;

    localparam pc_t STEP_IDLE      = 4'd0;
    localparam pc_t STEP_CHECK     = 4'd1;
    localparam pc_t STEP_TRACK     = 4'd2;
    localparam pc_t STEP_CH_INIT   = 4'd3;
    localparam pc_t STEP_CH_DIV    = 4'd4;
    localparam pc_t STEP_LEARN     = 4'd5;
    localparam pc_t STEP_RATE_INIT = 4'd6;
    localparam pc_t STEP_RATE_DIV  = 4'd7;
    localparam pc_t STEP_SET_RATE  = 4'd8;
    localparam pc_t STEP_LOCKED    = 4'd9;
    localparam pc_t STEP_EMIT      = 4'd10;

    typedef enum logic [3:0] {
        OP_ACCEPT,
        OP_NOP,
        OP_TRACK,
        OP_DIV_CH,
        OP_DIV_STEP,
        OP_LEARN,
        OP_DIV_RATE,
        OP_SET_RATE,
        OP_LOCKED,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NO_ITEM,
        COND_SHORT,
        COND_LOCKED,
        COND_NO_LEARN,
        COND_DIV_MORE,
        COND_NOT_LOCKED,
        COND_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
        logic  last;
    } uword_t;

    typedef struct packed {
        logic no_item;
        logic short_item;
        logic locked;
        logic no_learn;
        logic div_more;
        logic out_full;
    } flags_t;

    typedef struct packed {
        logic        load;
        logic        step;
        logic [17:0] dividend;
        logic [13:0] divisor;
        logic [4:0]  iters;
    } div_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  rate_code;
        logic [13:0] payload_channels;
        logic [6:0]  push_channels;
        logic [13:0] sample_count;
        logic        stamp_out_valid;
        logic [4:0]  stamp_sample_index;
        logic [31:0] stamp_time;
    } result_t;

    function automatic uword_t microcode(input pc_t pc);
        uword_t w;
        unique case (pc)
            STEP_IDLE:      w = '{OP_ACCEPT,   COND_NO_ITEM,    STEP_IDLE,      1'b0};
            STEP_CHECK:     w = '{OP_NOP,      COND_SHORT,      STEP_EMIT,      1'b0};
            STEP_TRACK:     w = '{OP_TRACK,    COND_LOCKED,     STEP_LOCKED,    1'b0};
            STEP_CH_INIT:   w = '{OP_DIV_CH,   COND_NO_LEARN,   STEP_EMIT,      1'b0};
            STEP_CH_DIV:    w = '{OP_DIV_STEP, COND_DIV_MORE,   STEP_CH_DIV,    1'b0};
            STEP_LEARN:     w = '{OP_LEARN,    COND_ALWAYS,     STEP_RATE_INIT, 1'b0};
            STEP_RATE_INIT: w = '{OP_DIV_RATE, COND_NOT_LOCKED, STEP_EMIT,      1'b0};
            STEP_RATE_DIV:  w = '{OP_DIV_STEP, COND_DIV_MORE,   STEP_RATE_DIV,  1'b0};
            STEP_SET_RATE:  w = '{OP_SET_RATE, COND_ALWAYS,     STEP_EMIT,      1'b0};
            STEP_LOCKED:    w = '{OP_LOCKED,   COND_ALWAYS,     STEP_EMIT,      1'b0};
            STEP_EMIT:      w = '{OP_EMIT,     COND_OUT_FULL,   STEP_EMIT,      1'b1};
            default:        w = '{OP_NOP,      COND_ALWAYS,     STEP_IDLE,      1'b0};
        endcase
        return w;
    endfunction

    function automatic logic [3:0] rate_of_quotient(input logic [13:0] q);
        logic [3:0] code;
        unique case (q)
            14'd1:   code = RATE_8K;
            14'd2:   code = RATE_16K;
            14'd4:   code = RATE_32K;
            14'd5:   code = RATE_44K1;
            14'd6:   code = RATE_48K;
            14'd11:  code = RATE_88K2;
            14'd12:  code = RATE_96K;
            14'd24:  code = RATE_192K;
            default: code = RATE_UNKNOWN;
        endcase
        return code;
    endfunction

    function automatic logic [5:0] syt_of_rate(input logic [3:0] code);
        logic [5:0] syt;
        unique case (code)
            RATE_8K:   syt = 6'd1;
            RATE_16K:  syt = 6'd2;
            RATE_32K, RATE_44K1, RATE_48K: syt = 6'd8;
            RATE_88K2, RATE_96K: syt = 6'd16;
            RATE_192K: syt = 6'd32;
            default:   syt = 6'd0;
        endcase
        return syt;
    endfunction

endpackage

FILE: hdl/isfl_seq.sv
module isfl_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  isfl_pkg::flags_t flags,
    output isfl_pkg::op_t   op
);
    import isfl_pkg::*;

    pc_t    pc_reg;
    pc_t    pc_next;
    uword_t uword;
    logic   take;

    assign uword = microcode(pc_reg);
    assign op    = uword.op;

    always_comb
    begin
        case (uword.cond)
            COND_ALWAYS:     take = 1'b1;
            COND_NO_ITEM:    take = flags.no_item;
            COND_SHORT:      take = flags.short_item;
            COND_LOCKED:     take = flags.locked;
            COND_NO_LEARN:   take = flags.no_learn;
            COND_DIV_MORE:   take = flags.div_more;
            COND_NOT_LOCKED: take = !flags.locked;
            COND_OUT_FULL:   take = flags.out_full;
            default:         take = 1'b0;
        endcase
    end

    always_comb
    begin
        if (take)
        begin
            pc_next = uword.target;
        end
        else if (uword.last)
        begin
            pc_next = STEP_IDLE;
        end
        else
        begin
            pc_next = pc_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: hdl/isfl_div.sv
module isfl_div (
    input  logic               clk,
    input  logic               rst_n,
    input  isfl_pkg::div_cmd_t cmd,
    output logic [17:0]        quotient,
    output logic               more
);
    import isfl_pkg::*;

    logic [17:0] q_reg;
    logic [17:0] q_next;
    logic [13:0] rem_reg;
    logic [13:0] rem_next;
    logic [13:0] div_reg;
    logic [13:0] div_next;
    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic [14:0] trial;
    logic [15:0] diff;
    logic        fits;

    assign trial    = {rem_reg, q_reg[17]};
    assign diff     = {1'b0, trial} - {2'b00, div_reg};
    assign fits     = !diff[15];
    assign quotient = q_reg;
    assign more     = (cnt_reg != 5'd1);

    always_comb
    begin
        q_next   = q_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            q_next   = cmd.dividend;
            rem_next = '0;
            div_next = cmd.divisor;
            cnt_next = cmd.iters;
        end
        else if (cmd.step)
        begin
            q_next   = {q_reg[16:0], fits};
            rem_next = fits ? diff[13:0] : trial[13:0];
            cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

endmodule

FILE: hdl/isfl_dp.sv
module isfl_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  isfl_pkg::op_t      op,
    input  logic               cfg_wr_en,
    input  logic [6:0]         cfg_wr_data,
    input  logic               in_valid,
    input  logic [7:0]         dbc,
    input  logic [15:0]        data_length,
    input  logic               timestamp_valid,
    input  logic [31:0]        presentation_time,
    input  logic [17:0]        quotient,
    input  logic               div_more,
    input  logic               out_full,
    output isfl_pkg::flags_t   flags,
    output isfl_pkg::div_cmd_t div_cmd,
    output isfl_pkg::result_t  result
);
    import isfl_pkg::*;

    logic [6:0]  listener_reg, listener_next;
    logic [7:0]  last_dbc_reg, last_dbc_next;
    logic [13:0] prev_cnt_reg, prev_cnt_next;
    logic [4:0]  lock_cnt_reg, lock_cnt_next;
    logic [13:0] pcc_reg, pcc_next;
    logic [17:0] acc_reg, acc_next;
    logic [3:0]  rate_reg, rate_next;

    logic [7:0]  dbc_reg, dbc_next;
    logic [15:0] len_reg, len_next;
    logic        tv_reg, tv_next;
    logic [31:0] pt_reg, pt_next;
    logic [7:0]  step_reg, step_next;
    logic [13:0] prev_reg, prev_next;

    logic [1:0]  res_status_reg, res_status_next;
    logic [6:0]  res_push_reg, res_push_next;
    logic [13:0] res_count_reg, res_count_next;
    logic        res_sv_reg, res_sv_next;
    logic [4:0]  res_sidx_reg, res_sidx_next;
    logic [31:0] res_stime_reg, res_stime_next;

    logic [15:0] len_body;
    logic [13:0] count_w;
    logic [13:0] ch_w;
    logic [5:0]  syt;
    logic [5:0]  syt_mask;
    logic [5:0]  sidx_w;
    logic [6:0]  push_w;

    assign len_body = len_reg - CIP_HEADER_BYTES;
    assign count_w  = len_body[15:2];
    assign ch_w     = quotient[13:0];
    assign syt      = syt_of_rate(rate_reg);
    assign syt_mask = syt - 6'd1;
    assign sidx_w   = (syt - ({1'b0, dbc_reg[4:0]} & syt_mask)) & syt_mask;
    assign push_w   = ({7'd0, listener_reg} < pcc_reg) ? listener_reg : pcc_reg[6:0];

    assign flags.no_item    = !in_valid;
    assign flags.short_item = (len_reg < CIP_HEADER_BYTES);
    assign flags.locked     = (lock_cnt_reg == LOCK_PACKETS);
    assign flags.no_learn   = (prev_reg == 14'd0) || (step_reg == 8'd0);
    assign flags.div_more   = div_more;
    assign flags.out_full   = out_full;

    assign div_cmd.load     = (op == OP_DIV_CH) || (op == OP_DIV_RATE);
    assign div_cmd.step     = (op == OP_DIV_STEP);
    assign div_cmd.dividend = (op == OP_DIV_CH) ? {prev_reg, 4'd0} : acc_reg;
    assign div_cmd.divisor  = (op == OP_DIV_CH) ? {6'd0, step_reg} : pcc_reg;
    assign div_cmd.iters    = (op == OP_DIV_CH) ? CH_ITERS : RATE_ITERS;

    assign result.status             = res_status_reg;
    assign result.rate_code          = rate_reg;
    assign result.payload_channels   = pcc_reg;
    assign result.push_channels      = res_push_reg;
    assign result.sample_count       = res_count_reg;
    assign result.stamp_out_valid    = res_sv_reg;
    assign result.stamp_sample_index = res_sidx_reg;
    assign result.stamp_time         = res_stime_reg;

    always_comb
    begin
        listener_next   = cfg_wr_en ? cfg_wr_data : listener_reg;
        last_dbc_next   = last_dbc_reg;
        prev_cnt_next   = prev_cnt_reg;
        lock_cnt_next   = lock_cnt_reg;
        pcc_next        = pcc_reg;
        acc_next        = acc_reg;
        rate_next       = rate_reg;
        dbc_next        = dbc_reg;
        len_next        = len_reg;
        tv_next         = tv_reg;
        pt_next         = pt_reg;
        step_next       = step_reg;
        prev_next       = prev_reg;
        res_status_next = res_status_reg;
        res_push_next   = res_push_reg;
        res_count_next  = res_count_reg;
        res_sv_next     = res_sv_reg;
        res_sidx_next   = res_sidx_reg;
        res_stime_next  = res_stime_reg;
        unique case (op)
            OP_ACCEPT:
            begin
                if (in_valid)
                begin
                    dbc_next        = dbc;
                    len_next        = data_length;
                    tv_next         = timestamp_valid;
                    pt_next         = presentation_time;
                    res_status_next = STATUS_SHORT;
                    res_push_next   = '0;
                    res_count_next  = '0;
                    res_sv_next     = 1'b0;
                    res_sidx_next   = '0;
                    res_stime_next  = '0;
                end
            end
            OP_TRACK:
            begin
                step_next       = dbc_reg - last_dbc_reg;
                prev_next       = prev_cnt_reg;
                last_dbc_next   = dbc_reg;
                prev_cnt_next   = count_w;
                res_count_next  = count_w;
                res_status_next = STATUS_LEARNING;
            end
            OP_LEARN:
            begin
                if ((pcc_reg == 14'd0) || (pcc_reg != ch_w))
                begin
                    pcc_next      = ch_w;
                    lock_cnt_next = 5'd1;
                    acc_next      = {4'd0, count_w};
                    rate_next     = RATE_UNKNOWN;
                end
                else
                begin
                    lock_cnt_next = lock_cnt_reg + 5'd1;
                    acc_next      = acc_reg + {4'd0, count_w};
                end
            end
            OP_SET_RATE:
            begin
                rate_next = (pcc_reg == 14'd0) ? RATE_UNKNOWN
                                               : rate_of_quotient(quotient[17:4]);
            end
            OP_LOCKED:
            begin
                res_status_next = STATUS_ACCEPTED;
                res_push_next   = push_w;
                if (tv_reg)
                begin
                    if (syt == 6'd0)
                    begin
                        res_status_next = STATUS_NO_RATE;
                        res_push_next   = '0;
                    end
                    else
                    begin
                        res_sv_next    = 1'b1;
                        res_sidx_next  = sidx_w[4:0];
                        res_stime_next = pt_reg;
                    end
                end
            end
            OP_NOP, OP_DIV_CH, OP_DIV_STEP, OP_DIV_RATE, OP_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listener_reg <= '0;
            last_dbc_reg <= '0;
            prev_cnt_reg <= '0;
            lock_cnt_reg <= '0;
            pcc_reg      <= '0;
            acc_reg      <= '0;
            rate_reg     <= RATE_UNKNOWN;
        end
        else
        begin
            listener_reg <= listener_next;
            last_dbc_reg <= last_dbc_next;
            prev_cnt_reg <= prev_cnt_next;
            lock_cnt_reg <= lock_cnt_next;
            pcc_reg      <= pcc_next;
            acc_reg      <= acc_next;
            rate_reg     <= rate_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dbc_reg        <= dbc_next;
        len_reg        <= len_next;
        tv_reg         <= tv_next;
        pt_reg         <= pt_next;
        step_reg       <= step_next;
        prev_reg       <= prev_next;
        res_status_reg <= res_status_next;
        res_push_reg   <= res_push_next;
        res_count_reg  <= res_count_next;
        res_sv_reg     <= res_sv_next;
        res_sidx_reg   <= res_sidx_next;
        res_stime_reg  <= res_stime_next;
    end

    // A known rate is only ever set once the lock has been reached.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rate_reg != RATE_UNKNOWN) |-> (lock_cnt_reg == LOCK_PACKETS))
        else $error("rate code set without lock");

    // Once locked, the block stays locked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (lock_cnt_reg == LOCK_PACKETS) |=> (lock_cnt_reg == LOCK_PACKETS))
        else $error("lock lost");

endmodule

FILE: hdl/iec61883_stream_format_lock.sv
// Learns the format of an IEC 61883-6 stream from parsed packets, one item per packet,
// and gives one result item per packet. A packet that is shorter than the CIP header,
// one that arrives once the stream is locked and one from which no channel count can be
// derived take a short path through the program. While learning, a packet also runs the
// channel pass of the shared shift-subtract divider, and the packet that completes the
// lock runs the rate pass as well: 14 steps for the channels and 18 steps for the rate,
// under a small microcode program that steps one control word a cycle. The last step
// waits for as long as the output register holds a stalled result. A new item is taken
// while the previous result still waits in the output register.
module iec61883_stream_format_lock (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  dbc,
    input  logic [15:0] data_length,
    input  logic        timestamp_valid,
    input  logic [31:0] presentation_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [3:0]  rate_code,
    output logic [13:0] payload_channels,
    output logic [6:0]  push_channels,
    output logic [13:0] sample_count,
    output logic        stamp_out_valid,
    output logic [4:0]  stamp_sample_index,
    output logic [31:0] stamp_time
);
    import isfl_pkg::*;

    op_t      op;
    flags_t   flags;
    div_cmd_t div_cmd;
    result_t  result;
    logic [17:0] quotient;
    logic        div_more;
    logic        out_full;
    logic        emit;

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg, out_res_next;

    assign in_stall = (op != OP_ACCEPT);
    assign out_full = out_valid_reg && out_stall;
    assign emit     = (op == OP_EMIT) && !out_full;

    isfl_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op)
    );

    isfl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .quotient (quotient),
        .more     (div_more)
    );

    isfl_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .op                (op),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .dbc               (dbc),
        .data_length       (data_length),
        .timestamp_valid   (timestamp_valid),
        .presentation_time (presentation_time),
        .quotient          (quotient),
        .div_more          (div_more),
        .out_full          (out_full),
        .flags             (flags),
        .div_cmd           (div_cmd),
        .result            (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_res_next   = result;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid          = out_valid_reg;
    assign status             = out_res_reg.status;
    assign rate_code          = out_res_reg.rate_code;
    assign payload_channels   = out_res_reg.payload_channels;
    assign push_channels      = out_res_reg.push_channels;
    assign sample_count       = out_res_reg.sample_count;
    assign stamp_out_valid    = out_res_reg.stamp_out_valid;
    assign stamp_sample_index = out_res_reg.stamp_sample_index;
    assign stamp_time         = out_res_reg.stamp_time;

    // The sequencer leaves its idle step as soon as an item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second item taken before the first was processed");

    // A forwarded timestamp only comes with an accepted packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stamp_out_valid) |-> (status == STATUS_ACCEPTED))
        else $error("timestamp forwarded for a packet that was not accepted");

    // A packet too short for the CIP header carries no samples and pushes nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_SHORT)) |->
            ((sample_count == 14'd0) && (push_channels == 7'd0)))
        else $error("short packet reported with samples");

endmodule

FILE: tb/iec61883_stream_format_lock_test.sv
`timescale 1ns / 1ps

module iec61883_stream_format_lock_test;

    import isfl_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [7:0]  dbc;
        logic [15:0] len;
        logic        tv;
        logic [31:0] pt;
        logic        typed;
        result_t     want;
    } packet_row_t;

    localparam result_t SHORT_AT_RESET =
        '{STATUS_SHORT, RATE_UNKNOWN, 14'd0, 7'd0, 14'd0, 1'b0, 5'd0, 32'd0};
    localparam result_t NOT_TYPED = '0;

    localparam packet_row_t DIRECTED_ROWS [23] = '{
        '{8'hFF, 16'd0,     1'b1, 32'hFFFF_FFFF, 1'b1, SHORT_AT_RESET},
        '{8'h00, 16'd7,     1'b0, 32'h0000_0000, 1'b1, SHORT_AT_RESET},
        '{8'h00, 16'hFFFF,  1'b1, 32'hA5A5_A5A5, 1'b1,
          '{STATUS_LEARNING, RATE_UNKNOWN, 14'd0, 7'd0, 14'd16381, 1'b0, 5'd0, 32'd0}},
        '{8'h00, 16'd8,     1'b0, 32'h5A5A_5A5A, 1'b1,
          '{STATUS_LEARNING, RATE_UNKNOWN, 14'd0, 7'd0, 14'd0, 1'b0, 5'd0, 32'd0}},
        '{8'h01, 16'd12,    1'b0, 32'h0000_0001, 1'b0, NOT_TYPED},
        '{8'h03, 16'd48,    1'b1, 32'h0000_0002, 1'b0, NOT_TYPED},
        '{8'h04, 16'd48,    1'b0, 32'h0000_0003, 1'b0, NOT_TYPED},
        '{8'h05, 16'd48,    1'b0, 32'h0000_0004, 1'b0, NOT_TYPED},
        '{8'h06, 16'd48,    1'b1, 32'h8000_0000, 1'b0, NOT_TYPED},
        '{8'h07, 16'd48,    1'b0, 32'h0000_0006, 1'b0, NOT_TYPED},
        '{8'h08, 16'd48,    1'b0, 32'h0000_0007, 1'b0, NOT_TYPED},
        '{8'h09, 16'd48,    1'b0, 32'h0000_0008, 1'b0, NOT_TYPED},
        '{8'h0A, 16'd5,     1'b1, 32'h0000_0009, 1'b0, NOT_TYPED},
        '{8'h0A, 16'd48,    1'b0, 32'h0000_000A, 1'b0, NOT_TYPED},
        '{8'h0A, 16'd48,    1'b0, 32'h0000_000B, 1'b0, NOT_TYPED},
        '{8'h0B, 16'd51,    1'b0, 32'h0000_000C, 1'b0, NOT_TYPED},
        '{8'h05, 16'd48,    1'b0, 32'h0000_000D, 1'b0, NOT_TYPED},
        '{8'hFF, 16'hFFFF,  1'b0, 32'h0000_000E, 1'b0, NOT_TYPED},
        '{8'h00, 16'd65532, 1'b0, 32'h0000_000F, 1'b0, NOT_TYPED},
        '{8'h01, 16'hFFFF,  1'b1, 32'h1234_5678, 1'b0, NOT_TYPED},
        '{8'h03, 16'd8,     1'b0, 32'h0000_0010, 1'b0, NOT_TYPED},
        '{8'h83, 16'd20,    1'b0, 32'h0000_0011, 1'b0, NOT_TYPED},
        '{8'hFF, 16'hFFFF,  1'b1, 32'hFFFF_FFFF, 1'b0, NOT_TYPED}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [6:0]  cfg_wr_data = 7'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  dbc = 8'd0;
    logic [15:0] data_length = 16'd0;
    logic        timestamp_valid = 1'b0;
    logic [31:0] presentation_time = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [3:0]  rate_code;
    logic [13:0] payload_channels;
    logic [6:0]  push_channels;
    logic [13:0] sample_count;
    logic        stamp_out_valid;
    logic [4:0]  stamp_sample_index;
    logic [31:0] stamp_time;

    logic [7:0]  seen_dbc = 8'd0;
    logic [13:0] seen_count = 14'd0;
    logic [4:0]  agree_count = 5'd0;
    logic [13:0] learned_channels = 14'd0;
    logic [17:0] sample_sum = 18'd0;
    logic [3:0]  learned_rate = RATE_UNKNOWN;
    logic [6:0]  listener_setting = 7'd0;

    result_t     results_due [$];
    result_t     observed;
    result_t     oldest;
    int          error_count = 0;
    int          packets_sent = 0;
    int          quiet_cycles = 0;
    int          stall_left = 0;
    logic        gaps_on = 1'b1;

    iec61883_stream_format_lock u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .dbc                (dbc),
        .data_length        (data_length),
        .timestamp_valid    (timestamp_valid),
        .presentation_time  (presentation_time),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .status             (status),
        .rate_code          (rate_code),
        .payload_channels   (payload_channels),
        .push_channels      (push_channels),
        .sample_count       (sample_count),
        .stamp_out_valid    (stamp_out_valid),
        .stamp_sample_index (stamp_sample_index),
        .stamp_time         (stamp_time)
    );

    assign observed = {status, rate_code, payload_channels, push_channels, sample_count,
                       stamp_out_valid, stamp_sample_index, stamp_time};

    always #2 clk = ~clk;

    function automatic result_t predict_packet(input logic [7:0] d, input logic [15:0] len,
                                               input logic tv, input logic [31:0] pt);
        result_t     r;
        logic [7:0]  step;
        logic [13:0] prev;
        logic [13:0] ch;
        logic [15:0] quads;
        logic [17:0] q;
        logic [7:0]  syt;
        logic [7:0]  mask;
        logic [7:0]  idx;
        r = '0;
        r.status = STATUS_SHORT;
        if (len >= CIP_HEADER_BYTES)
        begin
            step = d - seen_dbc;
            prev = seen_count;
            seen_dbc = d;
            quads = (len - CIP_HEADER_BYTES) >> 2;
            r.sample_count = quads[13:0];
            seen_count = quads[13:0];
            if (agree_count < LOCK_PACKETS)
            begin
                r.status = STATUS_LEARNING;
                if (prev != 14'd0 && step != 8'd0)
                begin
                    ch = prev / {6'd0, step};
                    if (learned_channels == 14'd0 || learned_channels != ch)
                    begin
                        learned_channels = ch;
                        agree_count = 5'd0;
                        sample_sum = 18'd0;
                        learned_rate = RATE_UNKNOWN;
                    end
                    sample_sum = sample_sum + {4'd0, quads[13:0]};
                    agree_count = agree_count + 5'd1;
                    if (agree_count == LOCK_PACKETS)
                    begin
                        q = 18'd0;
                        if (learned_channels != 14'd0)
                            q = sample_sum / {4'd0, learned_channels} / 18'd16;
                        case (q)
                            18'd1:   learned_rate = RATE_8K;
                            18'd2:   learned_rate = RATE_16K;
                            18'd4:   learned_rate = RATE_32K;
                            18'd5:   learned_rate = RATE_44K1;
                            18'd6:   learned_rate = RATE_48K;
                            18'd11:  learned_rate = RATE_88K2;
                            18'd12:  learned_rate = RATE_96K;
                            18'd24:  learned_rate = RATE_192K;
                            default: learned_rate = RATE_UNKNOWN;
                        endcase
                    end
                end
            end
            else
            begin
                r.status = STATUS_ACCEPTED;
                if (tv)
                begin
                    case (learned_rate)
                        RATE_8K:                       syt = 8'd1;
                        RATE_16K:                      syt = 8'd2;
                        RATE_32K, RATE_44K1, RATE_48K: syt = 8'd8;
                        RATE_88K2, RATE_96K:           syt = 8'd16;
                        RATE_192K:                     syt = 8'd32;
                        default:                       syt = 8'd0;
                    endcase
                    if (syt == 8'd0)
                    begin
                        r.status = STATUS_NO_RATE;
                    end
                    else
                    begin
                        mask = syt - 8'd1;
                        idx = (syt - (d & mask)) & mask;
                        r.stamp_out_valid = 1'b1;
                        r.stamp_sample_index = idx[4:0];
                        r.stamp_time = pt;
                    end
                end
                if (r.status == STATUS_ACCEPTED)
                begin
                    if ({7'd0, listener_setting} < learned_channels)
                        r.push_channels = listener_setting;
                    else
                        r.push_channels = learned_channels[6:0];
                end
            end
        end
        r.rate_code = learned_rate;
        r.payload_channels = learned_channels;
        return r;
    endfunction

    task automatic send_packet(input logic [7:0] d, input logic [15:0] len, input logic tv,
                               input logic [31:0] pt, input logic typed, input result_t want);
        result_t predicted;
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        dbc <= d;
        data_length <= len;
        timestamp_valid <= tv;
        presentation_time <= pt;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = predict_packet(d, len, tv, pt);
        results_due.push_back(typed ? want : predicted);
        packets_sent++;
    endtask

    task automatic write_listener(input logic [6:0] value);
        in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        listener_setting = value;
    endtask

    task automatic roam_learning(input int target);
        int pick;
        int s;
        int ch;
        int span;
        int n;
        while (packets_sent < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                s = $urandom_range(1, 100);
                span = 16381 / s;
                if (span > 200)
                    span = 200;
                ch = $urandom_range(0, span);
                n = $urandom_range(2, 12);
                repeat (n)
                    send_packet(seen_dbc + 8'(s), 16'(8 + 4 * ch * s + $urandom_range(0, 3)),
                                1'($urandom), $urandom, 1'b0, NOT_TYPED);
                send_packet(seen_dbc + 8'(2 * s), 16'($urandom), 1'($urandom), $urandom,
                            1'b0, NOT_TYPED);
            end
            else if (pick < 8)
            begin
                send_packet(8'($urandom), 16'($urandom), 1'($urandom), $urandom,
                            1'b0, NOT_TYPED);
            end
            else if (pick == 8)
            begin
                send_packet(8'($urandom), 16'($urandom_range(0, 7)), 1'($urandom), $urandom,
                            1'b0, NOT_TYPED);
            end
            else
            begin
                send_packet(seen_dbc, 16'(8 + 4 * $urandom_range(0, 16381)), 1'($urandom),
                            $urandom, 1'b0, NOT_TYPED);
            end
        end
    endtask

    task automatic lock_stream();
        int mapped_steps [8] = '{1, 2, 4, 5, 6, 11, 12, 24};
        int odd_steps [8] = '{3, 7, 9, 10, 13, 20, 48, 100};
        int s;
        int ch;
        int span;
        int guard;
        if ($urandom_range(0, 3) == 0)
            s = odd_steps[$urandom_range(0, 7)];
        else
            s = mapped_steps[$urandom_range(0, 7)];
        span = 16381 / s;
        if (span > 96)
            span = 96;
        ch = $urandom_range(1, span);
        guard = 0;
        while (agree_count < LOCK_PACKETS && guard < 40)
        begin
            if ($urandom_range(0, 9) == 0)
                send_packet(8'($urandom), 16'($urandom_range(0, 7)), 1'($urandom), $urandom,
                            1'b0, NOT_TYPED);
            else
                send_packet(seen_dbc + 8'(s), 16'(8 + 4 * ch * s + $urandom_range(0, 3)),
                            1'($urandom), $urandom, 1'b0, NOT_TYPED);
            guard++;
        end
    endtask

    task automatic run_locked(input int n);
        int pick;
        logic [15:0] len;
        repeat (n)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                len = 16'($urandom_range(0, 7));
            else if (pick < 4)
                len = 16'($urandom);
            else
                len = 16'(8 + 4 * $urandom_range(0, 16381) + $urandom_range(0, 3));
            send_packet(8'($urandom), len, 1'($urandom), $urandom, 1'b0, NOT_TYPED);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: result item with no expectation waiting, actual %h",
                         $time, observed);
                error_count++;
            end
            else
            begin
                oldest = results_due.pop_front();
                check_field("status", 32'(oldest.status), 32'(observed.status));
                check_field("rate_code", 32'(oldest.rate_code), 32'(observed.rate_code));
                check_field("payload_channels", 32'(oldest.payload_channels),
                            32'(observed.payload_channels));
                check_field("push_channels", 32'(oldest.push_channels),
                            32'(observed.push_channels));
                check_field("sample_count", 32'(oldest.sample_count),
                            32'(observed.sample_count));
                check_field("stamp_out_valid", 32'(oldest.stamp_out_valid),
                            32'(observed.stamp_out_valid));
                check_field("stamp_sample_index", 32'(oldest.stamp_sample_index),
                            32'(observed.stamp_sample_index));
                check_field("stamp_time", oldest.stamp_time, observed.stamp_time);
            end
        end
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!out_stall && gaps_on && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 16);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("iec61883_stream_format_lock verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_listener(7'd127);
        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
            send_packet(DIRECTED_ROWS[i].dbc, DIRECTED_ROWS[i].len, DIRECTED_ROWS[i].tv,
                        DIRECTED_ROWS[i].pt, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        write_listener(7'($urandom));
        roam_learning(720);
        lock_stream();
        write_listener(7'd0);
        run_locked(165);
        write_listener(7'd64);
        run_locked(165);
        write_listener(7'd1);
        run_locked(165);
        write_listener(7'd127);
        run_locked(165);
        write_listener(7'($urandom_range(0, 64)));
        gaps_on = 1'b0;
        run_locked(165);
        in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (error_count == 0 && results_due.size() == 0)
            $display("iec61883_stream_format_lock verification clean");
        else
            $display("iec61883_stream_format_lock verification failed");
        $finish;
    end

endmodule
